[design/plint_pkg.sv]
// ---------------------------------------------------------------------------
// plint_pkg: shared types and constants
// Breakpoint table geometry, entry layout and divider operand bundle.
// ---------------------------------------------------------------------------
package plint_pkg;

	localparam int MAX_POINTS = 256;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int COUNT_W    = 9;
	localparam int DATA_W     = 32;
	localparam int PROD_W     = 2 * DATA_W;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
	} entry_t;

	// magnitudes for |dx| * |dy| / |ds|
	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] d;
	} md_opnd_t;

endpackage

[design/plint_if.sv]
// ---------------------------------------------------------------------------
// plint_if: streaming channels
// Request channel (write or query) and response channel with valid/ready.
// ---------------------------------------------------------------------------
interface plint_req_if;
	import plint_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [7:0]               point_index;
	logic signed [DATA_W-1:0] x_value;
	logic signed [DATA_W-1:0] y_value;

	modport source (output valid, cmd, point_index, x_value, y_value, input ready);
	modport sink   (input valid, cmd, point_index, x_value, y_value, output ready);
endinterface

interface plint_rsp_if;
	import plint_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] y_result;
	logic                     defined;

	modport source (output valid, y_result, defined, input ready);
	modport sink   (input valid, y_result, defined, output ready);
endinterface

[design/plint_table.sv]
// ---------------------------------------------------------------------------
// plint_table: breakpoint memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module plint_table (
	input  logic                         clk,
	input  logic                         we,
	input  logic [plint_pkg::ADDR_W-1:0] waddr,
	input  plint_pkg::entry_t            wdata,
	input  logic [plint_pkg::ADDR_W-1:0] raddr,
	output plint_pkg::entry_t            rdata
);
	import plint_pkg::*;

	entry_t mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/plint_muldiv.sv]
// ---------------------------------------------------------------------------
// plint_muldiv: unsigned a*b/d
// A registered 32x32 multiply, then restoring division at two bits per cycle.
// ---------------------------------------------------------------------------
module plint_muldiv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  plint_pkg::md_opnd_t          opnd,
	output logic                         done,
	output logic [plint_pkg::PROD_W-1:0] quot
);
	import plint_pkg::*;

	localparam int STEPS = PROD_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV
	} state_t;

	state_t            state_q;
	md_opnd_t          opnd_q;
	logic [PROD_W-1:0] rq_q;      // dividend shifts out, quotient shifts in
	logic [DATA_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [PROD_W-1:0] rq_nx;
	logic [DATA_W-1:0] rem_nx;
	logic [DATA_W:0]   trial;

	always_comb begin
		rq_nx  = rq_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_nx, rq_nx[PROD_W-1]};
			if (trial >= {1'b0, opnd_q.d}) begin
				rem_nx = DATA_W'(trial - {1'b0, opnd_q.d});
				rq_nx  = {rq_nx[PROD_W-2:0], 1'b1};
			end else begin
				rem_nx = trial[DATA_W-1:0];
				rq_nx  = {rq_nx[PROD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			opnd_q <= opnd;
		end
		if (state_q == S_MUL) begin
			rq_q  <= opnd_q.a * opnd_q.b;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			rq_q  <= rq_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = rq_q;

endmodule

[design/piecewise_linear_interpolator.sv]
// Flow: a write transfer gives no result. A query with no value (count under 2, x at
//   or past either end point, or a zero-width segment) skips the divider; any other
//   query runs the binary search, the two segment reads and the divider.
// Requests: one item at a time; its pace is set by one table read per search step and
//   the radix-4 divider. A finished result waits in the output register.
// Reset: arst_n clears control state and point_count; the table is undefined until written.
// ---------------------------------------------------------------------------
// piecewise_linear_interpolator: table-driven linear interpolation
// Stores Q16.16 breakpoints and answers queries by binary search over the
// table followed by y0 + dx*dy/ds, truncated toward zero and saturated.
// ---------------------------------------------------------------------------
module piecewise_linear_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_count_we,
	input  logic [plint_pkg::COUNT_W-1:0] point_count_wdata,
	plint_req_if.sink                     req,
	plint_rsp_if.source                   rsp
);
	import plint_pkg::*;

	localparam int IDX_W = ADDR_W + 2;   // signed search bounds, -1 .. MAX_POINTS

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK0,     // entry 0 on the read bus
		S_LAST,     // entry n-1 on the read bus
		S_SRCH,     // entry mid on the read bus
		S_SEG0,     // left segment end on the read bus
		S_SEG1,     // right segment end on the read bus
		S_WAIT,     // divider busy
		S_RESULT    // result ready to go to the output register
	} state_t;

	state_t                   state_q;
	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       n_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] x0_q;
	logic signed [DATA_W-1:0] y0_q;
	logic signed [IDX_W-1:0]  lft_q;
	logic signed [IDX_W-1:0]  rgt_q;
	logic [ADDR_W-1:0]        mid_q;
	logic [ADDR_W-1:0]        seg_q;
	logic                     neg_q;
	logic signed [DATA_W-1:0] res_y_q;
	logic                     res_def_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_y_q;
	logic                     out_def_q;

	logic                     req_xfer;
	logic                     out_load;
	logic                     tbl_we;
	entry_t                   tbl_wdata;
	logic [ADDR_W-1:0]        raddr;
	entry_t                   rdata;

	logic                     md_start;
	md_opnd_t                 md_opnd;
	logic                     md_done;
	logic [PROD_W-1:0]        md_quot;

	// clamp of the loaded count to the table depth
	logic [COUNT_W-1:0]       n_in;
	logic [COUNT_W-1:0]       n_m1;

	// binary search step
	logic                     srch_le;
	logic signed [IDX_W-1:0]  lft_nx;
	logic signed [IDX_W-1:0]  rgt_nx;
	logic signed [IDX_W-1:0]  sum_nx;
	logic [ADDR_W-1:0]        mid_nx;
	logic                     srch_end;
	logic signed [IDX_W-1:0]  n_m2;
	logic [ADDR_W-1:0]        lft_cl;

	// segment arithmetic
	logic signed [DATA_W:0]   ds;
	logic signed [DATA_W:0]   dx;
	logic signed [DATA_W:0]   dy;
	logic [DATA_W:0]          ds_mag;
	logic [DATA_W:0]          dx_mag;
	logic [DATA_W:0]          dy_mag;

	// final sum and saturation
	logic                     q_big;
	logic signed [DATA_W+1:0] sum;
	logic signed [DATA_W-1:0] sat_y;

	assign req_xfer  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// result moves to the output register when that is empty or draining
	assign out_load = (state_q == S_RESULT) && (!out_valid_q || rsp.ready);

	assign tbl_we          = req_xfer && (req.cmd == CMD_WRITE);
	assign tbl_wdata.x     = req.x_value;
	assign tbl_wdata.y     = req.y_value;

	assign n_in = (count_q > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : count_q;
	assign n_m1 = n_q - 1'b1;

	always_comb begin
		srch_le  = (rdata.x <= x_q);
		lft_nx   = srch_le ? IDX_W'({2'b00, mid_q}) : lft_q;
		rgt_nx   = srch_le ? rgt_q : IDX_W'({2'b00, mid_q});
		sum_nx   = lft_nx + rgt_nx;
		mid_nx   = sum_nx[ADDR_W:1];
		srch_end = (rgt_nx - lft_nx) <= IDX_W'(1);
		n_m2     = IDX_W'({1'b0, n_q}) - IDX_W'(2);
		// out-of-order tables can leave the search off either end
		if (lft_nx < 0) begin
			lft_cl = '0;
		end else if (lft_nx > n_m2) begin
			lft_cl = n_m2[ADDR_W-1:0];
		end else begin
			lft_cl = lft_nx[ADDR_W-1:0];
		end
	end

	// read address for the entry wanted in the next state
	always_comb begin
		case (state_q)
			S_IDLE:  raddr = '0;
			S_CHK0:  raddr = n_m1[ADDR_W-1:0];
			S_LAST:  raddr = n_m1[ADDR_W:1];
			S_SRCH:  raddr = srch_end ? lft_cl : mid_nx;
			S_SEG0:  raddr = seg_q + 1'b1;
			default: raddr = '0;
		endcase
	end

	always_comb begin
		ds     = {rdata.x[DATA_W-1], rdata.x} - {x0_q[DATA_W-1], x0_q};
		dx     = {x_q[DATA_W-1], x_q} - {x0_q[DATA_W-1], x0_q};
		dy     = {rdata.y[DATA_W-1], rdata.y} - {y0_q[DATA_W-1], y0_q};
		ds_mag = ds[DATA_W] ? -ds : ds;
		dx_mag = dx[DATA_W] ? -dx : dx;
		dy_mag = dy[DATA_W] ? -dy : dy;
		md_opnd.a = dx_mag[DATA_W-1:0];
		md_opnd.b = dy_mag[DATA_W-1:0];
		md_opnd.d = ds_mag[DATA_W-1:0];
		md_start  = (state_q == S_SEG1) && (ds != '0);
	end

	// any quotient of 2^32 or more pushes the sum past the 32-bit range
	always_comb begin
		q_big = |md_quot[PROD_W-1:DATA_W];
		if (neg_q) begin
			sum = {{2{y0_q[DATA_W-1]}}, y0_q} - {2'b00, md_quot[DATA_W-1:0]};
		end else begin
			sum = {{2{y0_q[DATA_W-1]}}, y0_q} + {2'b00, md_quot[DATA_W-1:0]};
		end
		if (q_big) begin
			sat_y = neg_q ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sum > $signed({3'b000, {(DATA_W-1){1'b1}}})) begin
			sat_y = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sum < $signed({3'b111, {(DATA_W-1){1'b0}}})) begin
			sat_y = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat_y = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (point_count_we) begin
				count_q <= point_count_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer && req.cmd == CMD_QUERY) begin
						state_q <= (n_in < COUNT_W'(2)) ? S_RESULT : S_CHK0;
					end
				end
				S_CHK0: begin
					state_q <= (x_q <= rdata.x) ? S_RESULT : S_LAST;
				end
				S_LAST: begin
					state_q <= (x_q >= rdata.x) ? S_RESULT : S_SRCH;
				end
				S_SRCH: begin
					if (srch_end) begin
						state_q <= S_SEG0;
					end
				end
				S_SEG0: begin
					state_q <= S_SEG1;
				end
				S_SEG1: begin
					state_q <= md_start ? S_WAIT : S_RESULT;
				end
				S_WAIT: begin
					if (md_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q       <= req.x_value;
				n_q       <= n_in;
				res_y_q   <= '0;
				res_def_q <= 1'b0;
			end
			S_LAST: begin
				lft_q <= '1;
				rgt_q <= IDX_W'({1'b0, n_q});
				mid_q <= n_m1[ADDR_W:1];
			end
			S_SRCH: begin
				lft_q <= lft_nx;
				rgt_q <= rgt_nx;
				mid_q <= mid_nx;
				seg_q <= lft_cl;
			end
			S_SEG0: begin
				x0_q <= rdata.x;
				y0_q <= rdata.y;
			end
			S_SEG1: begin
				neg_q <= dx[DATA_W] ^ dy[DATA_W] ^ ds[DATA_W];
			end
			S_WAIT: begin
				if (md_done) begin
					res_y_q   <= sat_y;
					res_def_q <= 1'b1;
				end
			end
			S_RESULT: begin
				if (out_load) begin
					out_y_q   <= res_y_q;
					out_def_q <= res_def_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.y_result = out_y_q;
	assign rsp.defined  = out_def_q;

	plint_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (req.point_index),
		.wdata (tbl_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	plint_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.opnd   (md_opnd),
		.done   (md_done),
		.quot   (md_quot)
	);

endmodule

[dv/plint_interp_checker.sv]
// ---------------------------------------------------------------------------
// plint_interp_checker: breakpoint table scoreboard
// Mirrors table writes and the point count, predicts the answer to every
// accepted query and checks the response stream in order.
// ---------------------------------------------------------------------------
module plint_interp_checker
	import plint_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               count_we,
	input  logic [COUNT_W-1:0] count_wdata,
	plint_req_if               req,
	plint_rsp_if               rsp,
	output int                 mismatches,
	output int                 pending
);

	typedef struct packed {
		logic signed [DATA_W-1:0] y_result;
		logic                     defined;
	} answer_t;

	localparam longint      Y_MAX    = 64'sd2147483647;
	localparam longint      Y_MIN    = -64'sd2147483648;
	localparam logic [63:0] QUOT_CAP = 64'd1 << 40;

	logic signed [DATA_W-1:0] mirror_x [MAX_POINTS];
	logic signed [DATA_W-1:0] mirror_y [MAX_POINTS];
	logic [COUNT_W-1:0]       mirror_count;
	answer_t                  answers_due [$];
	answer_t                  oldest;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// search for the segment, then y0 + |dx|*|dy|/|ds| with sign, saturated
	function automatic answer_t interpolate(input logic signed [DATA_W-1:0] qx);
		answer_t      a;
		int           n, lo, hi, mid;
		longint       xq, x0, x1, y0, y1, dx, dy, ds, sum;
		logic [63:0]  mdx, mdy, mds, q;
		logic [127:0] quot;
		logic         neg;
		a  = '0;
		n  = (mirror_count > MAX_POINTS) ? MAX_POINTS : int'(mirror_count);
		xq = qx;
		if (n < 2)
			return a;
		if (xq <= longint'(mirror_x[0]) || xq >= longint'(mirror_x[n-1]))
			return a;
		lo = -1;
		hi = n;
		while (hi - lo > 1) begin
			mid = (hi + lo) / 2;
			if (longint'(mirror_x[mid]) <= xq)
				lo = mid;
			else
				hi = mid;
		end
		if (lo < 0)
			lo = 0;
		if (lo > n - 2)
			lo = n - 2;
		x0 = mirror_x[lo];
		x1 = mirror_x[lo+1];
		y0 = mirror_y[lo];
		y1 = mirror_y[lo+1];
		ds = x1 - x0;
		if (ds == 0)
			return a;
		dx   = xq - x0;
		dy   = y1 - y0;
		mdx  = (dx < 0) ? -dx : dx;
		mdy  = (dy < 0) ? -dy : dy;
		mds  = (ds < 0) ? -ds : ds;
		quot = ({64'd0, mdx} * {64'd0, mdy}) / {64'd0, mds};
		q    = (quot > {64'd0, QUOT_CAP}) ? QUOT_CAP : quot[63:0];
		neg  = ((dx < 0) != (dy < 0)) != (ds < 0);
		sum  = neg ? y0 - longint'(q) : y0 + longint'(q);
		if (sum > Y_MAX)
			sum = Y_MAX;
		if (sum < Y_MIN)
			sum = Y_MIN;
		a.y_result = sum[DATA_W-1:0];
		a.defined  = 1'b1;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_count = '0;
			answers_due.delete();
			mismatches   = 0;
			pending      = 0;
		end else begin
			// responses first: a response always belongs to an older query
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("response with no query waiting: y=%0d defined=%0b",
						rsp.y_result, rsp.defined));
				end else begin
					oldest = answers_due.pop_front();
					if (rsp.defined !== oldest.defined)
						report_mismatch($sformatf("defined: got %0b, want %0b",
							rsp.defined, oldest.defined));
					if (rsp.y_result !== oldest.y_result)
						report_mismatch($sformatf("y_result: got %0d, want %0d",
							rsp.y_result, oldest.y_result));
				end
			end
			if (count_we)
				mirror_count = count_wdata;
			if (req.valid && req.ready) begin
				if (req.cmd == CMD_WRITE) begin
					mirror_x[req.point_index] = req.x_value;
					mirror_y[req.point_index] = req.y_value;
				end else begin
					answers_due.push_back(interpolate(req.x_value));
				end
			end
			pending = answers_due.size();
		end
	end

endmodule

[dv/tb_piecewise_linear_interpolator.sv]
// ---------------------------------------------------------------------------
// tb_piecewise_linear_interpolator: testbench top
// Loads breakpoint tables (sorted, clustered, unsorted, full), sweeps the
// point count across its range and fires queries aimed at and around the
// breakpoints, with random gaps and stalls on both channels. A checker
// beside the block predicts and compares every answer.
// ---------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;
	import plint_pkg::*;

	// Slowest legal run: ~1250 transfers, each with its longest gap, its search and
	// divide and its longest stall, plus ~20 settles and one long hold-off. The limit
	// leaves ample headroom over that.
	localparam int CYCLE_LIMIT       = 500000;
	localparam int SETTLE_CYCLES     = 64;   // longer than the slowest query
	localparam int LONG_HOLD         = 300;
	localparam int PHASES            = 14;
	localparam int QUERIES_PER_PHASE = 50;
	localparam int COUNT_MAX         = (1 << COUNT_W) - 1;

	logic               clk               = 1'b0;
	logic               arst_n            = 1'b0;
	logic               point_count_we    = 1'b0;
	logic [COUNT_W-1:0] point_count_wdata = '0;
	int                 mismatches;
	int                 pending;
	int unsigned        cycles  = 0;
	bit                 quiet   = 1'b0;  // no idling at all on either side
	bit                 hold_go = 1'b0;  // asks the response side for its long hold-off
	int                 gap_pct = 0;     // odds of a gap before a request transfer
	int                 tbl_x [$];       // x values of the loaded table, to aim queries

	plint_req_if req_ch ();
	plint_rsp_if rsp_ch ();

	piecewise_linear_interpolator i_dut (
		.clk,
		.arst_n,
		.point_count_we,
		.point_count_wdata,
		.req (req_ch),
		.rsp (rsp_ch)
	);

	plint_interp_checker i_checker (
		.clk,
		.arst_n,
		.count_we    (point_count_we),
		.count_wdata (point_count_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches,
		.pending
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake or a lost response ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Response side. Ready changes only at the falling edge. Stall bursts of random
	// length, calm stretches with no stalls, and one long hold-off that lets the
	// block fill up and push back on the request channel.
	initial begin : response_sink
		int stall_left, calm_left, hold_left;
		bit hold_done, rdy;
		stall_left = 0;
		calm_left  = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (quiet || calm_left > 0) begin
				if (calm_left > 0)
					calm_left--;
				rdy = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3: begin
						stall_left = $urandom_range(1, 12) - 1;
						rdy = 1'b0;
					end
					4: begin
						calm_left = $urandom_range(50, 200);
						rdy = 1'b1;
					end
					default: rdy = 1'b1;
				endcase
			end
			rsp_ch.ready <= rdy;
		end
	end

	// One request transfer. Valid stays high after the transfer until the next
	// falling edge, where the next call either drops it for a gap or puts up
	// the next item; settle() drops it when no item follows.
	task automatic send_item(input cmd_t c, input logic [7:0] slot,
			input logic [DATA_W-1:0] xv, input logic [DATA_W-1:0] yv);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 12);
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= c;
		req_ch.point_index <= slot;
		req_ch.x_value     <= xv;
		req_ch.y_value     <= yv;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic put_point(input logic [7:0] slot, input logic [DATA_W-1:0] xv,
			input logic [DATA_W-1:0] yv);
		send_item(CMD_WRITE, slot, xv, yv);
	endtask

	// index and y are don't-care for a query; random so their bits toggle
	task automatic query(input logic [DATA_W-1:0] xv);
		send_item(CMD_QUERY, 8'($urandom), xv, $urandom);
	endtask

	// Quiet the request side, wait for every answer, then let a query that
	// produced no answer yet (none here, but writes linger) drain out.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// The count register is only touched with the block idle.
	task automatic set_count(input int n);
		settle();
		point_count_we    <= 1'b1;
		point_count_wdata <= n[COUNT_W-1:0];
		@(negedge clk);
		point_count_we    <= 1'b0;
	endtask

	// Fill slots 0..n-1. Wide tables spread x over the whole range; clustered
	// ones squeeze it into a narrow window so duplicate x values show up.
	task automatic load_table(input int n, input bit ordered);
		longint base, span, v;
		bit     wide_x, wide_y;
		int     yv;
		tbl_x.delete();
		wide_x = $urandom_range(0, 1);
		wide_y = $urandom_range(0, 1);
		base   = longint'($signed($urandom));
		case ($urandom_range(0, 2))
			0:       span = n;
			1:       span = 1 << 10;
			default: span = 1 << 22;
		endcase
		for (int i = 0; i < n; i++) begin
			if (wide_x) begin
				tbl_x.push_back($urandom);
			end else begin
				v = base + longint'($urandom_range(0, span));
				if (v > 64'sd2147483647)
					v = 64'sd2147483647;
				tbl_x.push_back(int'(v));
			end
		end
		if (ordered)
			tbl_x.sort();
		for (int i = 0; i < n; i++) begin
			yv = wide_y ? int'($urandom) : int'($urandom_range(0, 1 << 21)) - (1 << 20);
			put_point(i[7:0], tbl_x[i], yv);
		end
	endtask

	// Mostly inside the table's x span, with hits on breakpoints, on the
	// ends of the span and anywhere at all.
	function automatic int aim_query();
		longint lo, hi, v;
		lo = tbl_x[0];
		hi = tbl_x[0];
		foreach (tbl_x[i]) begin
			if (tbl_x[i] < lo)
				lo = tbl_x[i];
			if (tbl_x[i] > hi)
				hi = tbl_x[i];
		end
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return tbl_x[$urandom_range(0, tbl_x.size() - 1)];
			2: return $urandom_range(0, 1) ? int'(lo) : int'(hi);
			default: begin
				v = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
				return int'(v);
			end
		endcase
	endfunction

	initial begin : stimulus
		int           n, count;
		logic [7:0]   slot;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_WRITE;
		req_ch.point_index = '0;
		req_ch.x_value     = '0;
		req_ch.y_value     = '0;
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		set_count(0);
		query(32'h0000_0000);                           // empty table
		put_point(8'd0,   32'h8000_0000, 32'h7FFF_FFFF);
		put_point(8'd1,   32'h0000_0000, 32'h8000_0000);
		put_point(8'd2,   32'h0000_0000, 32'h0000_0000); // same x as slot 1: vertical step
		put_point(8'd3,   32'h7FFF_FFFF, 32'h7FFF_FFFF);
		put_point(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // top slot, rewritten before use
		set_count(1);
		query(32'h0001_0000);                           // a single point spans nothing
		set_count(4);
		query(32'h8000_0000);                           // at the first x
		query(32'h7FFF_FFFF);                           // at the last x
		query(32'h8000_0001);                           // just inside, full-range slope
		query(32'hFFFF_FFFF);
		query(32'h0000_0000);                           // lands on the duplicate x
		query(32'h0000_0001);
		query(32'h7FFF_FFFE);
		query(32'h4000_0000);
		// unsorted table: the search still settles on some segment
		put_point(8'd0, 32'hFF9C_0000, 32'h0000_0000);
		put_point(8'd1, 32'h0032_0000, 32'h7FFF_FFFF);
		put_point(8'd2, 32'hFFEC_0000, 32'h8000_0000);
		put_point(8'd3, 32'h000A_0000, 32'h0001_0000);
		put_point(8'd4, 32'h0064_0000, 32'h0000_0000);
		set_count(5);
		query(32'hFFE2_0000);
		query(32'h0014_0000);
		query(32'h003C_0000);

		// --- random part ---
		// Phase 4 loads a full table; phases 5 and 6 reuse it with counts past
		// the table size (5 at the register's top). Phases 7 and 11 are
		// unsorted. Phase 2 carries the long response hold-off, and the last
		// phase runs with no idling on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = (ph == PHASES - 1);
			if (quiet) begin
				gap_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0:       gap_pct = 0;
					1:       gap_pct = 15;
					2:       gap_pct = 30;
					default: gap_pct = 60;
				endcase
			end
			if (ph == 5) begin
				count = COUNT_MAX;
			end else if (ph == 6) begin
				count = $urandom_range(MAX_POINTS + 1, COUNT_MAX - 1);
			end else begin
				n = (ph == 4) ? MAX_POINTS : $urandom_range(2, 24);
				load_table(n, !(ph == 7 || ph == 11));
				count = n;
			end
			set_count(count);
			if (ph == 2)
				hold_go = 1'b1;
			for (int k = 0; k < QUERIES_PER_PHASE; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: junk above the live slots, or a new y on a live one
					if (tbl_x.size() < MAX_POINTS) begin
						put_point(8'($urandom_range(tbl_x.size(), MAX_POINTS - 1)),
							$urandom, $urandom);
					end else begin
						slot = 8'($urandom_range(0, MAX_POINTS - 1));
						put_point(slot, tbl_x[slot], $urandom);
					end
				end else begin
					query(aim_query());
				end
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
